FILE: src/nmt_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the NAT mapping table.
// Used by nmt_match and nat_mapping_table; no dependencies.
package nmt_pkg;

  typedef enum logic [1:0] {
    OP_LOOKUP_EXT = 2'd0,
    OP_LOOKUP_INT = 2'd1,
    OP_INSERT     = 2'd2,
    OP_TICK       = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_FOUND     = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_TICK_DONE = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CFG_EXTERNAL_IP = 2'd0,
    CFG_EXPIRY      = 2'd1,
    CFG_FIRST_PORT  = 2'd2
  } cfg_index_t;

  localparam logic       KIND_ICMP      = 1'b0;
  localparam logic [15:0] FIRST_PORT_RST = 16'd1024;
  localparam logic [15:0] EXPIRY_RST     = 16'd60;

  typedef struct packed {
    opcode_t     opcode;
    logic [31:0] internal_ip;
    logic [15:0] internal_port;
    logic [15:0] external_port;
    logic        mapping_kind;
  } req_t;

  typedef struct packed {
    status_t     status;
    logic [31:0] found_internal_ip;
    logic [15:0] found_internal_port;
    logic [31:0] found_external_ip;
    logic [15:0] found_external_port;
    logic        found_kind;
    logic [31:0] found_stamp;
  } rsp_t;

  // one table word
  typedef struct packed {
    logic        valid;
    logic [31:0] internal_ip;
    logic [15:0] internal_port;
    logic [31:0] external_ip;
    logic [15:0] external_port;
    logic        kind;
    logic [31:0] stamp;
    logic [31:0] age_order;
  } entry_t;

  // per-entry verdict from the compare unit
  typedef struct packed {
    logic        hit;
    logic        free;
    logic        expired;
    logic [31:0] order_gap;
  } eval_t;

endpackage

FILE: src/nmt_match.sv
`timescale 1ns / 1ps
// Compare unit shared by all operations: judges one table word per cycle.
// Depends on nmt_pkg.
module nmt_match (
  input  nmt_pkg::entry_t entry,
  input  nmt_pkg::req_t   req,
  input  logic [31:0]     now_seconds,
  input  logic [15:0]     expiry,
  input  logic [31:0]     newest_order,
  output nmt_pkg::eval_t  ev
);
  import nmt_pkg::*;

  logic [31:0] age;
  logic        key_eq;

  always_comb begin
    case (req.opcode)
      OP_LOOKUP_EXT: key_eq = entry.external_port == req.external_port;
      OP_LOOKUP_INT: key_eq = entry.internal_port == req.internal_port &&
                              entry.internal_ip == req.internal_ip;
      default:       key_eq = 1'b0;
    endcase
  end

  assign age          = now_seconds - entry.stamp;
  assign ev.hit       = entry.valid && entry.kind == req.mapping_kind && key_eq;
  assign ev.free      = !entry.valid;
  assign ev.expired   = entry.valid && entry.kind == KIND_ICMP && age > {16'd0, expiry};
  // wrapping distance from the newest insert; smaller is newer
  assign ev.order_gap = newest_order - entry.age_order;

endmodule

FILE: src/nat_mapping_table.sv
`timescale 1ns / 1ps
// NAT mapping table. One operation at a time, scanned through the table RAM
// one word per cycle by the shared compare unit (registered RAM read).
// Lookups and ticks scan every word; an insert stops at the first free slot.
// A new operation is taken only once the last result has been loaded into
// the output register, which waits while that result is stalled. After reset
// a clearing pass zeroes the valid bits; no operation is taken meanwhile.
module nat_mapping_table #(
  parameter int ENTRIES = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  nmt_pkg::req_t     in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output nmt_pkg::rsp_t     out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  nmt_pkg::cfg_index_t cfg_index,
  input  logic [31:0]       cfg_data
);
  import nmt_pkg::*;

  localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam logic [AW-1:0] LAST = AW'(ENTRIES - 1);

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_t;

  state_t      state;
  req_t        req;
  logic [31:0] external_ip;
  logic [15:0] expiry;
  logic [15:0] first_port;
  logic [15:0] next_port;
  logic [31:0] now_seconds;
  logic [31:0] newest_order;

  logic [AW-1:0] scan_addr;
  logic          issued_all;
  logic          rd_vld;
  logic [AW-1:0] rd_idx;
  entry_t        rd_data;
  entry_t        mem [ENTRIES];

  entry_t      best;
  logic [31:0] best_dist;
  logic        found;

  eval_t       ev;
  entry_t      new_entry;
  logic        issue;
  logic        last;
  logic        ins_hit;
  logic        exp_hit;
  logic        mem_we;
  logic [AW-1:0] mem_waddr;
  entry_t      mem_wdata;
  rsp_t        rsp_next;
  status_t     status_next;

  nmt_match u_match (
    .entry        (rd_data),
    .req          (req),
    .now_seconds  (now_seconds),
    .expiry       (expiry),
    .newest_order (newest_order),
    .ev           (ev)
  );

  assign in_stall  = state != S_IDLE;
  assign cfg_ready = 1'b1;

  assign issue   = state == S_SCAN && !issued_all;
  assign last    = rd_vld && rd_idx == LAST;
  assign ins_hit = state == S_SCAN && rd_vld && req.opcode == OP_INSERT && ev.free;
  assign exp_hit = state == S_SCAN && rd_vld && req.opcode == OP_TICK && ev.expired;
  assign mem_we  = state == S_CLEAR || ins_hit || exp_hit;

  always_comb begin
    new_entry.valid         = 1'b1;
    new_entry.internal_ip   = req.internal_ip;
    new_entry.internal_port = req.internal_port;
    new_entry.external_ip   = external_ip;
    new_entry.external_port = next_port;
    new_entry.kind          = req.mapping_kind;
    new_entry.stamp         = now_seconds;
    new_entry.age_order     = newest_order + 32'd1;
  end

  always_comb begin
    mem_waddr = rd_idx;
    mem_wdata = rd_data;
    mem_wdata.valid = 1'b0;
    if (state == S_CLEAR) begin
      mem_waddr = scan_addr;
      mem_wdata = '0;
    end else if (ins_hit) begin
      mem_wdata = new_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data <= mem[scan_addr];
  end

  always_comb begin
    case (req.opcode)
      OP_LOOKUP_EXT, OP_LOOKUP_INT: status_next = found ? ST_FOUND : ST_NOT_FOUND;
      OP_INSERT:                    status_next = found ? ST_FOUND : ST_FULL;
      default:                      status_next = ST_TICK_DONE;
    endcase
    rsp_next = '0;
    rsp_next.status = status_next;
    if (found) begin
      rsp_next.found_internal_ip   = best.internal_ip;
      rsp_next.found_internal_port = best.internal_port;
      rsp_next.found_external_ip   = best.external_ip;
      rsp_next.found_external_port = best.external_port;
      rsp_next.found_kind          = best.kind;
      rsp_next.found_stamp         = best.stamp;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      scan_addr    <= '0;
      issued_all   <= 1'b0;
      rd_vld       <= 1'b0;
      out_valid    <= 1'b0;
      found        <= 1'b0;
      external_ip  <= '0;
      expiry       <= EXPIRY_RST;
      first_port   <= FIRST_PORT_RST;
      next_port    <= FIRST_PORT_RST;
      now_seconds  <= '0;
      newest_order <= '1;
    end else begin
      rd_vld <= issue;
      rd_idx <= scan_addr;

      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_EXTERNAL_IP: external_ip <= cfg_data;
          CFG_EXPIRY:      expiry      <= cfg_data[15:0];
          CFG_FIRST_PORT:  first_port  <= cfg_data[15:0];
          default: ;
        endcase
      end

      // S_DONE loads the next result itself
      if (out_valid && !out_stall && state != S_DONE) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_CLEAR: begin
          scan_addr <= (scan_addr == LAST) ? '0 : scan_addr + AW'(1);
          if (scan_addr == LAST) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            req        <= in_data;
            scan_addr  <= '0;
            issued_all <= 1'b0;
            found      <= 1'b0;
            if (in_data.opcode == OP_TICK) begin
              now_seconds <= now_seconds + 32'd1;
            end
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (issue) begin
            scan_addr <= scan_addr + AW'(1);
            if (scan_addr == LAST) begin
              issued_all <= 1'b1;
            end
          end
          if (rd_vld) begin
            case (req.opcode)
              OP_LOOKUP_EXT, OP_LOOKUP_INT: begin
                if (ev.hit && (!found || ev.order_gap < best_dist)) begin
                  best      <= rd_data;
                  best_dist <= ev.order_gap;
                  found     <= 1'b1;
                end
                if (last) begin
                  state <= S_DONE;
                end
              end
              OP_INSERT: begin
                if (ev.free) begin
                  best         <= new_entry;
                  found        <= 1'b1;
                  newest_order <= newest_order + 32'd1;
                  next_port    <= (next_port == 16'hFFFF) ? first_port
                                                          : next_port + 16'd1;
                  state        <= S_DONE;
                end else if (last) begin
                  state <= S_DONE;
                end
              end
              default: begin
                if (last) begin
                  state <= S_DONE;
                end
              end
            endcase
          end
        end
        S_DONE: begin
          if (!out_valid || !out_stall) begin
            out_data  <= rsp_next;
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_no_write_idle: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> !mem_we)
    else $error("table written while idle");

  a_tick_advance: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && in_data.opcode == OP_TICK
      |=> now_seconds == $past(now_seconds) + 32'd1)
    else $error("seconds count not advanced by tick");

  a_insert_order: assert property (@(posedge clk) disable iff (rst)
    ins_hit |=> newest_order == $past(newest_order) + 32'd1)
    else $error("insert order not advanced");

  a_clear_sweep: assert property (@(posedge clk) disable iff (rst)
    state == S_CLEAR && scan_addr != LAST |=> state == S_CLEAR)
    else $error("clearing pass cut short");
`endif

endmodule

FILE: bench/nat_mapping_table_test.sv
`timescale 1ns / 1ps
// Self-checking bench for nat_mapping_table: directed and random table operations,
// every reply checked field by field against an in-bench copy of the table.
// Depends on nmt_pkg (types, codes, reset values) and the nat_mapping_table RTL.
module nat_mapping_table_test;
  import nmt_pkg::*;

  localparam int TABLE_SLOTS = 64;
  localparam logic KIND_TCP = 1'b1;
  localparam logic [1:0] REG_SPARE = 2'd3;

  logic clk = 1'b0;
  logic rst;
  logic in_valid;
  logic in_stall;
  req_t in_data;
  logic out_valid;
  logic out_stall;
  rsp_t out_data;
  logic cfg_valid;
  logic cfg_ready;
  cfg_index_t cfg_index;
  logic [31:0] cfg_data;

  // bench copy of the table and its registers
  logic        slot_used  [TABLE_SLOTS];
  logic [31:0] slot_iip   [TABLE_SLOTS];
  logic [15:0] slot_iport [TABLE_SLOTS];
  logic [31:0] slot_eip   [TABLE_SLOTS];
  logic [15:0] slot_eport [TABLE_SLOTS];
  logic        slot_kind  [TABLE_SLOTS];
  logic [31:0] slot_stamp [TABLE_SLOTS];
  logic [31:0] slot_seq   [TABLE_SLOTS];
  logic [31:0] seq_count;
  logic [31:0] seconds;
  logic [15:0] port_next;
  logic [31:0] reg_ext_ip;
  logic [15:0] reg_expiry;
  logic [15:0] reg_first_port;

  rsp_t table_replies[$];
  int   mismatches = 0;
  bit   input_jitter = 1'b1;
  bit   output_jitter = 1'b1;

  nat_mapping_table #(.ENTRIES(TABLE_SLOTS)) u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    out_stall <= output_jitter && ($urandom_range(99) < 19);
  end

  function automatic int first_free_slot();
    int s;
    for (s = 0; s < TABLE_SLOTS; s++) begin
      if (!slot_used[s]) return s;
    end
    return -1;
  endfunction

  function automatic rsp_t slot_reply(input int s);
    rsp_t rep;
    rep = '0;
    rep.status              = ST_FOUND;
    rep.found_internal_ip   = slot_iip[s];
    rep.found_internal_port = slot_iport[s];
    rep.found_external_ip   = slot_eip[s];
    rep.found_external_port = slot_eport[s];
    rep.found_kind          = slot_kind[s];
    rep.found_stamp         = slot_stamp[s];
    return rep;
  endfunction

  // Applies one operation to the bench table and returns the reply it must produce.
  function automatic rsp_t apply_op(input req_t r);
    rsp_t rep;
    int s;
    int hit_slot;
    logic hit;
    logic [31:0] gap;
    logic [31:0] best_gap;
    rep = '0;
    hit_slot = -1;
    best_gap = '0;
    case (r.opcode)
      OP_LOOKUP_EXT, OP_LOOKUP_INT: begin
        for (s = 0; s < TABLE_SLOTS; s++) begin
          if (r.opcode == OP_LOOKUP_EXT)
            hit = slot_eport[s] == r.external_port;
          else
            hit = slot_iport[s] == r.internal_port && slot_iip[s] == r.internal_ip;
          if (slot_used[s] && slot_kind[s] == r.mapping_kind && hit) begin
            // newest entry wins: smallest wrapping distance from the last insert
            gap = seq_count - 32'd1 - slot_seq[s];
            if (hit_slot < 0 || gap < best_gap) begin
              hit_slot = s;
              best_gap = gap;
            end
          end
        end
        if (hit_slot < 0)
          rep.status = ST_NOT_FOUND;
        else
          rep = slot_reply(hit_slot);
      end
      OP_INSERT: begin
        s = first_free_slot();
        if (s < 0) begin
          rep.status = ST_FULL;
        end else begin
          slot_used[s]  = 1'b1;
          slot_iip[s]   = r.internal_ip;
          slot_iport[s] = r.internal_port;
          slot_eip[s]   = reg_ext_ip;
          slot_eport[s] = port_next;
          slot_kind[s]  = r.mapping_kind;
          slot_stamp[s] = seconds;
          slot_seq[s]   = seq_count;
          seq_count     = seq_count + 32'd1;
          port_next     = (port_next == 16'hFFFF) ? reg_first_port : port_next + 16'd1;
          rep = slot_reply(s);
        end
      end
      default: begin
        seconds = seconds + 32'd1;
        for (s = 0; s < TABLE_SLOTS; s++) begin
          if (slot_used[s] && slot_kind[s] == KIND_ICMP &&
              (seconds - slot_stamp[s]) > {16'd0, reg_expiry})
            slot_used[s] = 1'b0;
        end
        rep.status = ST_TICK_DONE;
      end
    endcase
    return rep;
  endfunction

  function automatic req_t make_op(input opcode_t op, input logic [31:0] ip,
                                   input logic [15:0] iport, input logic [15:0] eport,
                                   input logic kind);
    req_t r;
    r.opcode        = op;
    r.internal_ip   = ip;
    r.internal_port = iport;
    r.external_port = eport;
    r.mapping_kind  = kind;
    return r;
  endfunction

  // fields the operation does not use carry random values
  function automatic req_t random_op(input opcode_t op, input logic kind);
    return make_op(op, $urandom(), 16'($urandom()), 16'($urandom()), kind);
  endfunction

  function automatic int pick_live_slot();
    int start;
    int k;
    start = $urandom_range(TABLE_SLOTS - 1);
    for (k = 0; k < TABLE_SLOTS; k++) begin
      if (slot_used[(start + k) % TABLE_SLOTS]) return (start + k) % TABLE_SLOTS;
    end
    return -1;
  endfunction

  task automatic issue_op(input req_t r);
    if (input_jitter && $urandom_range(99) < 19) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 2 * TABLE_SLOTS)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= r;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    table_replies.push_back(apply_op(r));
  endtask

  // wait for every reply, then leave the block idle
  task automatic settle();
    in_valid <= 1'b0;
    while (table_replies.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic program_regs(input logic [31:0] ip, input logic [15:0] expiry,
                              input logic [15:0] fport);
    cfg_index_t  idx [4];
    logic [31:0] val [4];
    int k;
    idx[0] = CFG_EXTERNAL_IP;
    idx[1] = CFG_EXPIRY;
    idx[2] = CFG_FIRST_PORT;
    idx[3] = cfg_index_t'(REG_SPARE);
    val[0] = ip;
    val[1] = {16'($urandom()), expiry};
    val[2] = {16'($urandom()), fport};
    val[3] = $urandom();
    for (k = 0; k < 4; k++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[k];
      cfg_data  <= val[k];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
    end
    cfg_valid <= 1'b0;
    reg_ext_ip     = ip;
    reg_expiry     = expiry;
    reg_first_port = fport;
  endtask

  task automatic test_directed_ops();
    issue_op(make_op(OP_LOOKUP_EXT, 32'h0, 16'h0, 16'h0000, KIND_ICMP));
    issue_op(make_op(OP_LOOKUP_EXT, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, KIND_TCP));
    issue_op(make_op(OP_LOOKUP_INT, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, KIND_TCP));
    issue_op(make_op(OP_TICK, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, KIND_TCP));
    issue_op(make_op(OP_INSERT, 32'h0, 16'h0, 16'hFFFF, KIND_ICMP));
    issue_op(make_op(OP_INSERT, 32'hFFFF_FFFF, 16'hFFFF, 16'h0, KIND_ICMP));
    issue_op(make_op(OP_INSERT, 32'h0, 16'h0, 16'h0, KIND_ICMP));
    issue_op(make_op(OP_LOOKUP_EXT, 32'h0, 16'h0, FIRST_PORT_RST, KIND_ICMP));
    issue_op(make_op(OP_LOOKUP_EXT, 32'h0, 16'h0, FIRST_PORT_RST, KIND_TCP));
    // duplicate internal key: the later insert must be returned
    issue_op(make_op(OP_LOOKUP_INT, 32'h0, 16'h0, 16'h0, KIND_ICMP));
    issue_op(make_op(OP_LOOKUP_INT, 32'hFFFF_FFFF, 16'hFFFE, 16'h0, KIND_ICMP));
    issue_op(make_op(OP_LOOKUP_INT, 32'hFFFF_FFFE, 16'hFFFF, 16'h0, KIND_ICMP));
    issue_op(make_op(OP_LOOKUP_INT, 32'hFFFF_FFFF, 16'hFFFF, 16'h0, KIND_ICMP));
  endtask

  task automatic test_icmp_expiry();
    req_t probe;
    probe = make_op(OP_LOOKUP_INT, 32'h0A00_0001, 16'd7, 16'd0, KIND_ICMP);
    settle();
    program_regs(32'hC0A8_0001, EXPIRY_RST, FIRST_PORT_RST);
    issue_op(make_op(OP_INSERT, 32'h0A00_0001, 16'd7, 16'($urandom()), KIND_ICMP));
    repeat (60) issue_op(random_op(OP_TICK, 1'($urandom())));
    issue_op(probe);   // age equal to the limit is kept
    issue_op(random_op(OP_TICK, KIND_ICMP));
    issue_op(probe);
    settle();
    program_regs(32'hFFFF_FFFF, 16'hFFFF, FIRST_PORT_RST);
    issue_op(make_op(OP_INSERT, 32'h0A00_0001, 16'd7, 16'd0, KIND_ICMP));
    repeat (2) issue_op(random_op(OP_TICK, KIND_TCP));
    issue_op(probe);
    settle();
    program_regs(32'h8000_0000, 16'd1, FIRST_PORT_RST);
    issue_op(random_op(OP_TICK, KIND_ICMP));
    issue_op(probe);
    issue_op(make_op(OP_INSERT, 32'h0A00_0001, 16'd7, 16'd0, KIND_ICMP));
    issue_op(random_op(OP_TICK, KIND_ICMP));
    issue_op(probe);
    issue_op(random_op(OP_TICK, KIND_ICMP));
    issue_op(probe);
    settle();
    program_regs(32'h0000_0001, 16'd0, FIRST_PORT_RST);
    issue_op(make_op(OP_INSERT, 32'h0A00_0001, 16'd7, 16'd0, KIND_ICMP));
    issue_op(probe);
    issue_op(random_op(OP_TICK, KIND_ICMP));
    issue_op(probe);
  endtask

  // Insert bursts that each tick clears, back to back without any idling, then
  // new wrap targets that must leave the running port counter alone.
  task automatic test_port_counter();
    settle();
    input_jitter = 1'b0;
    output_jitter = 1'b0;
    program_regs($urandom(), 16'd0, 16'hFFFF);
    repeat (4) begin
      repeat (12) issue_op(random_op(OP_INSERT, KIND_ICMP));
      issue_op(random_op(OP_TICK, KIND_ICMP));
    end
    settle();
    program_regs($urandom(), 16'd0, 16'h0000);
    repeat (4) issue_op(random_op(OP_INSERT, KIND_ICMP));
    issue_op(make_op(OP_LOOKUP_EXT, $urandom(), 16'($urandom()), port_next - 16'd1,
                     KIND_ICMP));
    issue_op(random_op(OP_TICK, KIND_ICMP));
    settle();
    input_jitter = 1'b1;
    output_jitter = 1'b1;
  endtask

  task automatic test_tcp_entries();
    settle();
    program_regs(32'h5A5A_A5A5, 16'd0, FIRST_PORT_RST);
    issue_op(make_op(OP_INSERT, 32'hFFFF_FFFF, 16'h0000, 16'($urandom()), KIND_TCP));
    issue_op(make_op(OP_INSERT, 32'h0000_0000, 16'hFFFF, 16'($urandom()), KIND_TCP));
    repeat (2) issue_op(random_op(OP_TICK, KIND_ICMP));
    issue_op(make_op(OP_LOOKUP_INT, 32'hFFFF_FFFF, 16'h0000, 16'($urandom()), KIND_TCP));
    issue_op(make_op(OP_LOOKUP_INT, 32'h0000_0000, 16'hFFFF, 16'($urandom()), KIND_TCP));
    issue_op(make_op(OP_LOOKUP_INT, 32'h0000_0000, 16'hFFFF, 16'($urandom()), KIND_ICMP));
    issue_op(make_op(OP_LOOKUP_EXT, $urandom(), 16'($urandom()), port_next - 16'd1,
                     KIND_TCP));
    issue_op(make_op(OP_LOOKUP_EXT, $urandom(), 16'($urandom()), port_next - 16'd1,
                     KIND_ICMP));
  endtask

  task automatic run_traffic(input int count);
    req_t r;
    int s;
    int roll;
    repeat (count) begin
      r = random_op(OP_TICK, $urandom_range(3) == 0);
      roll = $urandom_range(99);
      s = pick_live_slot();
      if (roll < 35) begin
        r.opcode = OP_INSERT;
        if (s >= 0 && $urandom_range(3) == 0) begin
          r.internal_ip   = slot_iip[s];
          r.internal_port = slot_iport[s];
          r.mapping_kind  = slot_kind[s];
        end
      end else if (roll < 60) begin
        r.opcode = OP_LOOKUP_EXT;
        if (s >= 0 && $urandom_range(3) != 0) begin
          r.external_port = slot_eport[s];
          r.mapping_kind  = slot_kind[s];
        end
      end else if (roll < 85) begin
        r.opcode = OP_LOOKUP_INT;
        if (s >= 0 && $urandom_range(3) != 0) begin
          r.internal_ip   = slot_iip[s];
          r.internal_port = slot_iport[s];
          r.mapping_kind  = slot_kind[s];
        end
      end
      issue_op(r);
    end
  endtask

  task automatic test_mixed_traffic();
    settle();
    program_regs($urandom(), 16'd0, 16'd1);
    run_traffic(40);
    settle();
    program_regs(32'hFFFF_FFFF, 16'd3, 16'($urandom()));
    run_traffic(40);
    settle();
    program_regs(32'h0000_0000, 16'hFFFF, 16'hFFFF);
    run_traffic(40);
    settle();
    program_regs($urandom(), 16'd2, 16'h0000);
    run_traffic(40);
  endtask

  task automatic test_table_full();
    settle();
    program_regs($urandom(), 16'd0, FIRST_PORT_RST);
    issue_op(random_op(OP_TICK, KIND_ICMP));
    while (first_free_slot() >= 0)
      issue_op(random_op(OP_INSERT, $urandom_range(3) == 0));
    // refused inserts must leave the port counter alone
    issue_op(random_op(OP_INSERT, KIND_ICMP));
    issue_op(random_op(OP_INSERT, KIND_TCP));
    issue_op(make_op(OP_LOOKUP_EXT, $urandom(), 16'($urandom()), port_next - 16'd1,
                     slot_kind[TABLE_SLOTS - 1]));
    issue_op(random_op(OP_TICK, KIND_TCP));
    repeat (2) issue_op(random_op(OP_INSERT, 1'($urandom())));
  endtask

  function automatic void check_field(input string field, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", field, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    rsp_t want;
    if (!rst && out_valid && !out_stall) begin
      if (table_replies.size() == 0) begin
        $error("reply transfer with no operation outstanding");
        mismatches++;
      end else begin
        want = table_replies.pop_front();
        check_field("status", 32'(want.status), 32'(out_data.status));
        check_field("found_internal_ip", want.found_internal_ip, out_data.found_internal_ip);
        check_field("found_internal_port", 32'(want.found_internal_port),
                    32'(out_data.found_internal_port));
        check_field("found_external_ip", want.found_external_ip, out_data.found_external_ip);
        check_field("found_external_port", 32'(want.found_external_port),
                    32'(out_data.found_external_port));
        check_field("found_kind", 32'(want.found_kind), 32'(out_data.found_kind));
        check_field("found_stamp", want.found_stamp, out_data.found_stamp);
      end
    end
  end

  initial begin
    int s;
    for (s = 0; s < TABLE_SLOTS; s++) slot_used[s] = 1'b0;
    seq_count      = '0;
    seconds        = '0;
    port_next      = FIRST_PORT_RST;
    reg_ext_ip     = '0;
    reg_expiry     = EXPIRY_RST;
    reg_first_port = FIRST_PORT_RST;
    rst       <= 1'b1;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= CFG_EXTERNAL_IP;
    cfg_data  <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_directed_ops();
    test_icmp_expiry();
    test_port_counter();
    test_tcp_entries();
    test_mixed_traffic();
    test_table_full();
    settle();
    repeat (TABLE_SLOTS + 8) @(posedge clk);
    if (mismatches == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

  initial begin
    #300_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
